### hw/rtl/argb_porter_duff_blend_top_assert.svh
// assertion macros used by the checker file
`ifndef ARGB_PORTER_DUFF_BLEND_TOP_ASSERT_SVH
`define ARGB_PORTER_DUFF_BLEND_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define APDB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apdb assertion failed");

// expression holds at every sampled edge out of reset
`define APDB_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("apdb assertion failed");

`endif

### hw/rtl/apdb_pkg.sv
`timescale 1ns / 1ps

package apdb_pkg;

  typedef enum logic [3:0] {
    MODE_SRC_OVER = 4'd0,
    MODE_SRC_ATOP = 4'd1,
    MODE_SRC_IN   = 4'd2,
    MODE_SRC_OUT  = 4'd3,
    MODE_DST_ATOP = 4'd4,
    MODE_DST_IN   = 4'd5,
    MODE_DST_OUT  = 4'd6,
    MODE_DST_OVER = 4'd7,
    MODE_LIGHTER  = 4'd8,
    MODE_COPY     = 4'd9,
    MODE_XOR      = 4'd10
  } mode_t;

  localparam int NUM_CH    = 3;
  localparam int DIV_STEPS = 8;
  // accept edge to result strobe, in edges
  localparam int LATENCY   = 13;

  // one classified pixel handed from front to back
  typedef struct packed {
    logic                          blend;
    logic [31:0]                   plain_pix;
    logic [8:0]                    fa;
    logic signed [NUM_CH-1:0][17:0] num;
  } entry_t;

  // one divider stage
  typedef struct packed {
    logic                    blend;
    logic [31:0]             plain_pix;
    logic [8:0]              fa;
    logic [NUM_CH-1:0][16:0] rem;
    logic [NUM_CH-1:0][7:0]  quo;
    logic [NUM_CH-1:0]       sat;
  } stage_t;

  // queue status toward the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hw/rtl/argb_porter_duff_blend_top.sv
`timescale 1ns / 1ps

// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------
// input    | start / busy           | in_src_color, in_coverage, in_dst_pixel
// result   | out_valid (strobe)     | out_new_pixel
// config   | cfg_valid / cfg_ready  | cfg_composite_mode
//
// one pixel per clock, sustained; the strobe is registered along this path after the transfer:
// 2 front stages, queue, divider load, 8 quotient stages, output register
// rst_n is synchronous; it clears the mode register and all valid flags
// the receiver cannot stall: the back end drains the queue every cycle,
// so busy stays low and cfg_ready stays high

module argb_porter_duff_blend_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_src_color,
  input  logic [7:0]  in_coverage,
  input  logic [31:0] in_dst_pixel,
  output logic        out_valid,
  output logic [31:0] out_new_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_composite_mode
);

  logic              acc;
  logic              push;
  apdb_pkg::entry_t  push_entry;
  apdb_pkg::entry_t  head;
  apdb_pkg::q_stat_t qstat;
  logic              pop;

  // the queue only fills if the back end ever stalls, which it never does
  assign busy      = qstat.full;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  // front: coverage scaling, alpha gating, mode classification, products
  apdb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .src_color  (in_src_color),
    .coverage   (in_coverage),
    .dst_pixel  (in_dst_pixel),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_mode   (cfg_composite_mode),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue, popped whenever it holds an entry
  assign pop = !qstat.empty;

  apdb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (qstat)
  );

  // back: pipelined divide with clamp, then the output register
  apdb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (pop),
    .entry     (head),
    .out_valid (out_valid),
    .out_pixel (out_new_pixel)
  );

endmodule

### hw/rtl/apdb_front.sv
`timescale 1ns / 1ps

module apdb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [31:0]         src_color,
  input  logic [7:0]          coverage,
  input  logic [31:0]         dst_pixel,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_mode,
  output logic                push,
  output apdb_pkg::entry_t    push_entry
);

  apdb_pkg::mode_t mode_r;

  // stage 1
  logic            v1_r;
  logic [31:0]     src1_r, dst1_r;
  logic [15:0]     aprod1_r;
  apdb_pkg::mode_t mode1_r;

  // stage 2
  logic        v2_r;
  logic        blend2_r;
  logic [31:0] plain2_r;
  logic [7:0]  sa2_r, da2_r;
  logic [15:0] faprod2_r;
  logic [apdb_pkg::NUM_CH-1:0][15:0]        ps2_r;
  logic signed [apdb_pkg::NUM_CH-1:0][17:0] pd2_r;

  logic [7:0] sa_raw, da_raw, sa_g, da_g;
  logic       s, d;
  logic [31:0] plain_nxt;
  logic       blend_nxt;
  logic [8:0] sum9;
  logic signed [8:0] adiff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= apdb_pkg::MODE_SRC_OVER;
    end else if (cfg_we) begin
      mode_r <= apdb_pkg::mode_t'(cfg_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
    end
  end

  // coverage scaling of source alpha
  always_ff @(posedge clk) begin
    src1_r   <= src_color;
    dst1_r   <= dst_pixel;
    mode1_r  <= mode_r;
    aprod1_r <= 16'((9'(src_color[31:24]) + 9'd1) * 9'(coverage));
  end

  assign sa_raw = aprod1_r[15:8];
  assign da_raw = dst1_r[31:24];
  assign s = (sa_raw != 8'd0);
  assign d = (da_raw != 8'd0);

  // alpha gating per mode
  always_comb begin
    sa_g = sa_raw;
    da_g = da_raw;
    unique case (mode1_r)
      apdb_pkg::MODE_SRC_ATOP: begin
        if (!(s && d)) begin
          sa_g = 8'd0;
          if (!d) da_g = 8'd0;
        end
      end
      apdb_pkg::MODE_SRC_IN: begin
        if (!(s && d)) begin sa_g = 8'd0; da_g = 8'd0; end
      end
      apdb_pkg::MODE_SRC_OUT: begin
        if (!(s && !d)) begin sa_g = 8'd0; da_g = 8'd0; end
      end
      apdb_pkg::MODE_DST_ATOP: begin
        if (s && d) sa_g = 8'd0;
        else if (s) da_g = 8'd0;
        else begin sa_g = 8'd0; da_g = 8'd0; end
      end
      apdb_pkg::MODE_DST_IN: begin
        sa_g = 8'd0;
        if (!(s && d)) da_g = 8'd0;
      end
      apdb_pkg::MODE_DST_OUT: begin
        sa_g = 8'd0;
        if (!(!s && d)) da_g = 8'd0;
      end
      apdb_pkg::MODE_DST_OVER: begin
        sa_g = 8'd0;
        if (!d) da_g = 8'd0;
      end
      apdb_pkg::MODE_COPY: da_g = 8'd0;
      default: ;
    endcase
  end

  always_comb begin
    plain_nxt = {sa_g, src1_r[23:0]};
    blend_nxt = 1'b0;
    sum9      = 9'd0;
    case (mode1_r)
      apdb_pkg::MODE_LIGHTER: begin
        for (int c = 0; c < apdb_pkg::NUM_CH; c++) begin
          sum9 = 9'(src1_r[c*8 +: 8]) + 9'(dst1_r[c*8 +: 8]);
          plain_nxt[c*8 +: 8] = sum9[8] ? 8'hFF : sum9[7:0];
        end
      end
      apdb_pkg::MODE_XOR: plain_nxt[23:0] = src1_r[23:0] ^ dst1_r[23:0];
      default: blend_nxt = (da_g != 8'd0) && (sa_g != 8'hFF);
    endcase
  end

  assign adiff = $signed(9'(da_g)) - $signed(9'(sa_g));

  always_ff @(posedge clk) begin
    blend2_r  <= blend_nxt;
    plain2_r  <= plain_nxt;
    sa2_r     <= sa_g;
    da2_r     <= da_g;
    faprod2_r <= 16'((9'(da_g) + 9'd1) * 9'(sa_g));
    for (int c = 0; c < apdb_pkg::NUM_CH; c++) begin
      ps2_r[c] <= 16'(src1_r[c*8 +: 8]) * 16'(sa_g);
      pd2_r[c] <= 18'($signed({1'b0, dst1_r[c*8 +: 8]}) * adiff);
    end
  end

  always_comb begin
    push                 = v2_r;
    push_entry.blend     = blend2_r;
    push_entry.plain_pix = plain2_r;
    push_entry.fa        = 9'(da2_r) + 9'(sa2_r) - 9'(faprod2_r[15:8]);
    for (int c = 0; c < apdb_pkg::NUM_CH; c++) begin
      push_entry.num[c] = $signed({2'b00, ps2_r[c]}) + pd2_r[c];
    end
  end

endmodule

### hw/rtl/apdb_queue.sv
`timescale 1ns / 1ps

module apdb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  apdb_pkg::entry_t  push_entry,
  input  logic              pop,
  output apdb_pkg::entry_t  head,
  output apdb_pkg::q_stat_t stat
);

  apdb_pkg::entry_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

endmodule

### hw/rtl/apdb_back.sv
`timescale 1ns / 1ps

module apdb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  apdb_pkg::entry_t entry,
  output logic             out_valid,
  output logic [31:0]      out_pixel
);

  localparam int NS = apdb_pkg::DIV_STEPS;

  apdb_pkg::stage_t stg_r [NS+1];
  logic [NS:0]      vld_r;
  apdb_pkg::stage_t stg0_nxt;
  logic             ov_r;
  logic [31:0]      opix_r;
  logic [31:0]      opix_nxt;

  // load: clamp non-positive numerators to zero, flag quotient overflow
  always_comb begin
    stg0_nxt.blend     = entry.blend;
    stg0_nxt.plain_pix = entry.plain_pix;
    stg0_nxt.fa        = entry.fa;
    for (int c = 0; c < apdb_pkg::NUM_CH; c++) begin
      stg0_nxt.quo[c] = 8'd0;
      if ($signed(entry.num[c]) > 18'sd0) begin
        stg0_nxt.rem[c] = entry.num[c][16:0];
        stg0_nxt.sat[c] = (entry.num[c][16:0] >= {entry.fa, 8'h00});
      end else begin
        stg0_nxt.rem[c] = 17'd0;
        stg0_nxt.sat[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_vld;
    stg_r[0] <= stg0_nxt;
  end

  // one restoring quotient bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_div
    apdb_pkg::stage_t nxt;
    logic [16:0]      dsh;

    assign dsh = 17'({stg_r[k].fa, 8'h00} >> (k + 1));

    always_comb begin
      nxt = stg_r[k];
      for (int c = 0; c < apdb_pkg::NUM_CH; c++) begin
        if (stg_r[k].rem[c] >= dsh) begin
          nxt.rem[c]           = stg_r[k].rem[c] - dsh;
          nxt.quo[c][NS-1-k]   = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k+1] <= 1'b0;
      else        vld_r[k+1] <= vld_r[k];
      stg_r[k+1] <= nxt;
    end
  end

  always_comb begin
    if (stg_r[NS].blend) begin
      opix_nxt[31:24] = stg_r[NS].fa[8] ? 8'hFF : stg_r[NS].fa[7:0];
      for (int c = 0; c < apdb_pkg::NUM_CH; c++) begin
        opix_nxt[c*8 +: 8] = stg_r[NS].sat[c] ? 8'hFF : stg_r[NS].quo[c];
      end
    end else begin
      opix_nxt = stg_r[NS].plain_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= vld_r[NS];
    opix_r <= opix_nxt;
  end

  assign out_valid = ov_r;
  assign out_pixel = opix_r;

endmodule

### hw/rtl/apdb_checker.sv
`timescale 1ns / 1ps
`include "argb_porter_duff_blend_top_assert.svh"

module apdb_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_ready
);

  `APDB_ASSERT_IMP(a_out_has_transfer, clk, rst_n, out_valid, $past(start && !busy && rst_n, apdb_pkg::LATENCY))
  `APDB_ASSERT_IMP(a_no_out_after_reset, clk, rst_n, !$past(rst_n), !out_valid)
  `APDB_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
  `APDB_ASSERT_ALWAYS(a_cfg_ready, clk, rst_n, cfg_ready)

endmodule

bind argb_porter_duff_blend_top apdb_checker u_apdb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_ready (cfg_ready)
);
